// File: rtl/core/mts_pkg.sv
// Shared types and constants for the min-tracking stack.
// No dependencies; imported by mts_cell and min_tracking_stack.
`default_nettype none

package mts_pkg;

	localparam int DEPTH  = 1024;
	localparam int DATA_W = 32;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_W-1:0] OP_POP   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] ST_MIN   = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// Shift command broadcast to every cell of the row.
	typedef struct packed {
		logic push;
		logic pop;
	} mts_shift_t;

endpackage

`default_nettype wire

// File: rtl/core/mts_cell.sv
// One slot of the stack row: holds the running minimum of its depth.
// Depends on mts_pkg.
`default_nettype none

module mts_cell (
	input  wire logic                      clk,
	input  wire mts_pkg::mts_shift_t       shift,
	input  wire logic [mts_pkg::DATA_W-1:0] from_above,
	input  wire logic [mts_pkg::DATA_W-1:0] from_below,
	output logic      [mts_pkg::DATA_W-1:0] min_q
);
	import mts_pkg::*;

	// push moves the row one slot deeper, pop one slot shallower; idle holds
	always_ff @(posedge clk) begin
		if (shift.push) begin
			min_q <= from_above;
		end else if (shift.pop) begin
			min_q <= from_below;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/min_tracking_stack.sv
// Top level of the min-tracking stack: fill counter, cell row, result register.
// Depends on mts_pkg and mts_cell.
`default_nettype none

// LIFO stack of signed 32-bit values that reports its minimum on request.
// Storage is a row of DEPTH cells (mts_pkg::DEPTH, 1024); cell 0 is always the
// top of stack and each cell holds the minimum of itself and everything below
// it, so a query reads cell 0 only. A push shifts the whole row one cell
// deeper with the new running minimum entering cell 0; a pop shifts it back.
// A new beat is accepted each cycle; the limit is the single result register,
// which holds the input off only while a result waits and res_ready is low.
// Push gives no result unless the stack is full (status 2, drop). Pop gives
// a result only when empty (status 1).
// Query returns status 0 with the minimum, or status 1 when empty.
// min_value is zero whenever status is not 0. Op code 3 is ignored.
// Cell contents are not reset; only the fill count and result valid are.
module min_tracking_stack (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_ready,
	input  wire logic [mts_pkg::OP_W-1:0]    op,
	input  wire logic signed [mts_pkg::DATA_W-1:0] push_value,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output logic      [mts_pkg::STAT_W-1:0]  status,
	output logic signed [mts_pkg::DATA_W-1:0] min_value
);
	import mts_pkg::*;

	logic [CNT_W-1:0]  fill_q;
	logic [DATA_W-1:0] cell_min [DEPTH];
	logic              accept;
	logic              is_empty;
	logic              is_full;
	logic [DATA_W-1:0] push_min;
	mts_shift_t        shift;
	logic              res_fire;
	logic [STAT_W-1:0] res_status;
	logic [DATA_W-1:0] res_min;
	logic              res_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] min_value_q;

	// Accept whenever the result slot is free or drains this cycle.
	assign item_ready = !res_valid_q || res_ready;
	assign accept     = item_valid && item_ready;
	assign is_empty   = (fill_q == '0);
	assign is_full    = (fill_q == CNT_W'(DEPTH));

	// New running minimum for the incoming top entry.
	always_comb begin
		push_min = push_value;
		if (!is_empty && ($signed(cell_min[0]) < push_value)) begin
			push_min = cell_min[0];
		end
	end

	// Decode the beat into a row shift and an optional result.
	always_comb begin
		shift.push = 1'b0;
		shift.pop  = 1'b0;
		res_fire   = 1'b0;
		res_status = ST_MIN;
		res_min    = '0;
		if (accept) begin
			unique case (op)
				OP_PUSH: begin
					if (is_full) begin
						res_fire   = 1'b1;
						res_status = ST_FULL;
					end else begin
						shift.push = 1'b1;
					end
				end
				OP_POP: begin
					if (is_empty) begin
						res_fire   = 1'b1;
						res_status = ST_EMPTY;
					end else begin
						shift.pop = 1'b1;
					end
				end
				OP_QUERY: begin
					res_fire = 1'b1;
					if (is_empty) begin
						res_status = ST_EMPTY;
					end else begin
						res_min = cell_min[0];
					end
				end
				default: begin
					// unused code: no effect
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (shift.push) begin
			fill_q <= fill_q + CNT_W'(1);
		end else if (shift.pop) begin
			fill_q <= fill_q - CNT_W'(1);
		end
	end

	// Cell row: cell i takes cell i-1 on push, cell i+1 on pop.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] above;
		logic [DATA_W-1:0] below;
		if (i == 0) begin : g_top
			assign above = push_min;
		end else begin : g_mid_a
			assign above = cell_min[i-1];
		end
		if (i == DEPTH - 1) begin : g_bot
			assign below = '0;
		end else begin : g_mid_b
			assign below = cell_min[i+1];
		end
		mts_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.from_above (above),
			.from_below (below),
			.min_q      (cell_min[i])
		);
	end

	// Result register; it parts the input from the output side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_fire) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			status_q    <= res_status;
			min_value_q <= res_min;
		end
	end

	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign min_value = $signed(min_value_q);

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking bench for min_tracking_stack: directed and random push, pop and query beats.
// Depends on mts_pkg and the min_tracking_stack RTL; a local stack model predicts each result.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mts_pkg::*;

	// Op code 3 has no name in the package; the block must ignore it.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Idle cycles (nothing accepted on either side) before the run is declared hung.
	// The longest legal quiet stretch is the forced receiver hold below.
	localparam int HOLD_CYCLES = 300;
	localparam int HANG_LIMIT  = 2000;

	typedef struct {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] min_value;
	} stack_result_t;

	logic                        clk;
	logic                        arst_n;
	logic                        item_valid;
	logic                        item_ready;
	logic [OP_W-1:0]             op;
	logic signed [DATA_W-1:0]    push_value;
	logic                        res_valid;
	logic                        res_ready;
	logic [STAT_W-1:0]           status;
	logic signed [DATA_W-1:0]    min_value;

	// Local copy of the stack: only the running minimum per slot matters for results.
	logic signed [DATA_W-1:0]    run_min [DEPTH];
	int                          stack_fill;
	int                          peak_fill;
	stack_result_t               due_results [$];

	int error_count;
	int beats_in;
	int results_out;
	int full_drops;
	int empty_reports;
	int idle_cycles;
	int burst_left;
	bit hold_req;

	min_tracking_stack i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.op         (op),
		.push_value (push_value),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.status     (status),
		.min_value  (min_value)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// One line per mismatch; the count decides the verdict.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %h, want %h (t=%0t)", what, got, want, $realtime);
		error_count++;
	endtask

	// Advance the model by one accepted beat and queue any result it owes.
	function automatic void track_min_op(input logic [OP_W-1:0] o,
			input logic signed [DATA_W-1:0] v);
		stack_result_t            r;
		logic signed [DATA_W-1:0] m;
		r.min_value = '0;
		case (o)
			OP_PUSH: begin
				if (stack_fill == DEPTH) begin
					// full: value dropped, state untouched
					r.status = ST_FULL;
					due_results.push_back(r);
					full_drops++;
				end else begin
					m = v;
					if (stack_fill > 0 && run_min[stack_fill-1] < m)
						m = run_min[stack_fill-1];
					run_min[stack_fill] = m;
					stack_fill++;
					if (stack_fill > peak_fill)
						peak_fill = stack_fill;
				end
			end
			OP_POP: begin
				if (stack_fill == 0) begin
					r.status = ST_EMPTY;
					due_results.push_back(r);
					empty_reports++;
				end else begin
					stack_fill--;
				end
			end
			OP_QUERY: begin
				if (stack_fill == 0) begin
					r.status = ST_EMPTY;
					empty_reports++;
				end else begin
					r.status    = ST_MIN;
					r.min_value = run_min[stack_fill-1];
				end
				due_results.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// Drive one beat at the falling edge and hold it until accepted. The sender
	// works in bursts: valid stays high through a burst, then drops for a gap.
	task automatic send_beat(input logic [OP_W-1:0] o, input logic signed [DATA_W-1:0] v);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
			if (gap > 0) begin
				item_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 12);
		end
		item_valid = 1'b1;
		op         = o;
		push_value = v;
		do @(posedge clk); while (!item_ready);
		burst_left--;
		beats_in++;
		track_min_op(o, v);
	endtask

	// Values lean toward the extremes and a narrow band so the minimum moves often.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2, 3:    return $signed($urandom_range(0, 200)) - 100;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op(input int push_pct, input int pop_pct,
			input int query_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			return OP_PUSH;
		if (r < push_pct + pop_pct)
			return OP_POP;
		if (r < push_pct + pop_pct + query_pct)
			return OP_QUERY;
		return OP_UNUSED;
	endfunction

	// Pop and query on an empty stack both report empty; op 3 is silent.
	task automatic test_empty_stack();
		send_beat(OP_QUERY, 32'sd0);
		send_beat(OP_POP, -32'sd1);
		send_beat(OP_UNUSED, 32'sh7FFF_FFFF);
		send_beat(OP_QUERY, 32'sh5555_5555);
	endtask

	// Most positive and most negative values, ties of the minimum on pop,
	// and an ignored op in the middle of a non-empty stack.
	task automatic test_extreme_values();
		send_beat(OP_PUSH, 32'sh7FFF_FFFF);
		send_beat(OP_QUERY, 32'sd0);
		send_beat(OP_PUSH, 32'sh8000_0000);
		send_beat(OP_QUERY, 32'sd0);
		send_beat(OP_PUSH, 32'sd0);
		send_beat(OP_QUERY, 32'sd0);
		send_beat(OP_POP, 32'sd0);
		send_beat(OP_POP, 32'sd0);
		send_beat(OP_QUERY, 32'sd0);
		send_beat(OP_PUSH, -32'sd1);
		send_beat(OP_QUERY, 32'sd0);
		send_beat(OP_PUSH, 32'sd1);
		send_beat(OP_QUERY, 32'sd0);
		send_beat(OP_UNUSED, 32'sh8000_0000);
		send_beat(OP_QUERY, 32'sd0);
		send_beat(OP_POP, 32'sd0);
		send_beat(OP_POP, 32'sd0);
		send_beat(OP_POP, 32'sd0);
		send_beat(OP_QUERY, 32'sd0);
		send_beat(OP_POP, 32'sd0);
	endtask

	// Receiver goes quiet for a long stretch while queries keep coming, so the
	// result register fills and item_ready must drop until the hold ends.
	task automatic test_backpressure();
		repeat (4) send_beat(OP_PUSH, pick_value());
		hold_req = 1'b1;
		repeat (40) send_beat(pick_op(20, 10, 70), pick_value());
	endtask

	// Balanced mix that keeps the stack shallow and often empty.
	task automatic test_random_shallow(input int n);
		repeat (n) send_beat(pick_op(35, 35, 25), pick_value());
	endtask

	// Push-heavy walk up to DEPTH, then churn at the top so full drops,
	// pops from full and refills all occur.
	task automatic test_climb_to_full();
		while (stack_fill < DEPTH)
			send_beat(pick_op(88, 4, 6), pick_value());
		repeat (80) send_beat(pick_op(50, 25, 20), pick_value());
	endtask

	// Receiver stall pattern: a mode is chosen for a random stretch of cycles.
	// A hold request from a test overrides everything for HOLD_CYCLES.
	initial begin : receiver
		int mode;
		int mode_left;
		int phase;
		res_ready = 1'b0;
		mode      = 0;
		mode_left = 0;
		phase     = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				phase++;
				case (mode)
					0:       res_ready = 1'b1;
					1:       res_ready = $urandom_range(0, 1);
					2:       res_ready = ($urandom_range(0, 3) == 0);
					default: res_ready = phase[0];
				endcase
			end
		end
	end

	// Result checker: every accepted result beat is matched against the oldest
	// prediction, field by field.
	always @(posedge clk) begin : result_check
		stack_result_t want;
		if (arst_n && res_valid && res_ready) begin
			results_out++;
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing pending", {30'd0, status}, 32'd0);
			end else begin
				want = due_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", {30'd0, status}, {30'd0, want.status});
				if (min_value !== want.min_value)
					report_mismatch("min_value", min_value, want.min_value);
			end
		end
	end

	// Hang detector: counts cycles where neither channel moves a beat.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("TIMEOUT: no beat for %0d cycles, %0d results pending",
				HANG_LIMIT, due_results.size());
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		op          = OP_QUERY;
		push_value  = '0;
		stack_fill  = 0;
		peak_fill   = 0;
		error_count = 0;
		beats_in    = 0;
		results_out = 0;
		full_drops  = 0;
		empty_reports = 0;
		idle_cycles = 0;
		burst_left  = 0;
		hold_req    = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_stack();
		test_extreme_values();
		test_backpressure();
		test_random_shallow(150);
		test_climb_to_full();

		// Drain: stop offering, wait for every owed result, then a short tail
		// to catch any stray result beat.
		@(negedge clk);
		item_valid = 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run covered %0d beats in and %0d results out, peak depth %0d of %0d.",
			beats_in, results_out, peak_fill, DEPTH);
		$display("Full drops %0d, empty reports %0d, mismatches %0d.",
			full_drops, empty_reports, error_count);
		if (error_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/mts_pkg.sv
rtl/core/mts_cell.sv
rtl/core/min_tracking_stack.sv
sim/tb.sv
